>>> rtl/extreme_pixel_neighbour_blanking_macros.svh
// assertion macros for the blanking block
`ifndef EXTREME_PIXEL_NEIGHBOUR_BLANKING_MACROS_SVH
`define EXTREME_PIXEL_NEIGHBOUR_BLANKING_MACROS_SVH

`define EPNB_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

`define EPNB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/epnb_pkg.sv
package epnb_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int SUM_W = 20;

  localparam logic [6:0] RESET_WIDTH  = 7'd10;
  localparam logic [6:0] RESET_HEIGHT = 7'd10;
  localparam logic [7:0] RESET_TARGET = 8'd100;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [7:0] inverted_out;
    logic [7:0] frame_average;
    logic       last;
  } out_item_t;

endpackage

>>> rtl/extreme_pixel_neighbour_blanking.sv
// read: the row, index / width (0..63), is found by repeated subtraction of the width, then
// the neighbours are read through one memory port; the last pixel of a frame adds repeated
// subtraction for the average (held at 255). loads may follow back to back while no read is
// in flight; one read in flight, input reopens after its result is taken and frame_done is seen.
// reset (rst, synchronous) empties the frame and restores the register defaults;
// frame store contents are undefined until loaded
module extreme_pixel_neighbour_blanking import epnb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
`include "extreme_pixel_neighbour_blanking_macros.svh"
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [6:0] frame_width, frame_height;
  logic [7:0] target_level;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] total;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      target_level <= RESET_TARGET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  frame_width  <= pwdata[6:0];
        REG_HEIGHT: frame_height <= pwdata[6:0];
        REG_TARGET: target_level <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, frame_width};
      REG_HEIGHT: prdata = {25'd0, frame_height};
      REG_TARGET: prdata = {24'd0, target_level};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (frame_width == 7'd0) eff_w = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(frame_width);
    if (frame_height == 7'd0) eff_h = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(frame_height);
    total = CW'(eff_w) * CW'(eff_h);
  end

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data, run_max, run_min;
  logic          job_valid, job_ready, job_last, frame_done, out_valid;
  logic [CW-1:0] job_idx;

  epnb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .push, .full, .item(in_item), .eff_w, .eff_h, .total,
    .wr_en, .wr_addr, .wr_data, .run_max, .run_min,
    .job_valid, .job_ready, .job_idx, .job_last, .frame_done
  );

  epnb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .run_max, .run_min,
    .target(target_level), .eff_w, .eff_h, .total,
    .job_valid, .job_ready, .job_idx, .job_last, .frame_done,
    .out_valid, .out_take(pop), .out_item
  );

  assign empty = !out_valid;

  `EPNB_ASSERT_IMPL(a_inv, clk, rst, !empty,
    out_item.inverted_out == 8'd255 - out_item.pixel_out, "inversion mismatch")
  `EPNB_ASSERT_IMPL(a_full_busy, clk, rst, !empty, full, "accepting while result waits")
  `EPNB_ASSERT_NEXT(a_pop, clk, rst, !empty && pop, empty, "result delivered twice")
endmodule

>>> rtl/epnb_front.sv
// front: loads go to the frame store, reads are checked and queued as jobs
module epnb_front import epnb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  in_item_t       item,
  input  logic [WW-1:0]  eff_w,
  input  logic [HW-1:0]  eff_h,
  input  logic [CW-1:0]  total,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_data,
  output logic [7:0]     run_max,
  output logic [7:0]     run_min,
  output logic           job_valid,
  input  logic           job_ready,
  output logic [CW-1:0]  job_idx,
  output logic           job_last,
  input  logic           frame_done
);
  logic [CW-1:0] load_index;
  logic [CW-1:0] read_index;
  logic          pend;
  logic          acc;
  logic          ld_ok;

  // one job in flight at a time; back end reports each result taken
  assign full  = job_valid || pend;
  assign acc   = push && !full;
  assign ld_ok = (load_index < total);

  assign wr_en   = acc && item.operation == OP_LOAD && ld_ok;
  assign wr_addr = load_index[AW-1:0];
  assign wr_data = item.pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      read_index <= '0;
      run_max    <= 8'd0;
      run_min    <= 8'd255;
      job_valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (frame_done) begin
        pend <= 1'b0;
      end
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
        pend      <= 1'b1;
      end
      if (frame_done && job_last) begin
        load_index <= '0;
        read_index <= '0;
        run_max    <= 8'd0;
        run_min    <= 8'd255;
      end else if (frame_done) begin
        read_index <= read_index + 1'b1;
      end
      if (wr_en) begin
        load_index <= load_index + 1'b1;
        if (item.pixel_in > run_max) run_max <= item.pixel_in;
        if (item.pixel_in < run_min) run_min <= item.pixel_in;
      end else if (acc && item.operation == OP_READ && !ld_ok) begin
        if (read_index >= total) begin
          load_index <= '0;
          read_index <= '0;
          run_max    <= 8'd0;
          run_min    <= 8'd255;
        end else begin
          job_valid <= 1'b1;
          job_idx   <= read_index;
          job_last  <= (read_index + 1'b1 >= total);
        end
      end
    end
  end

  logic unused_sz;
  assign unused_sz = ^{eff_w, eff_h};
endmodule

>>> rtl/epnb_back.sv
// back: walks the neighbours through one memory port, then divides for the mean on a frame's last pixel
module epnb_back import epnb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [7:0]     wr_data,
  input  logic [7:0]     run_max,
  input  logic [7:0]     run_min,
  input  logic [7:0]     target,
  input  logic [WW-1:0]  eff_w,
  input  logic [HW-1:0]  eff_h,
  input  logic [CW-1:0]  total,
  input  logic           job_valid,
  output logic           job_ready,
  input  logic [CW-1:0]  job_idx,
  input  logic           job_last,
  output logic           frame_done,
  output logic           out_valid,
  input  logic           out_take,
  output out_item_t      out_item
);
  typedef enum logic [2:0] {S_IDLE, S_POS, S_NB, S_DIV, S_OUT} state_t;
  state_t state;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] idx;
  logic          lst;
  logic [HW-1:0] row;
  logic [WW-1:0] col;
  logic [CW-1:0] rem;
  logic [3:0]    k;
  logic          rd_pend;
  logic          hit;
  logic [SUM_W-1:0] psum;
  logic [SUM_W-1:0] quo_rem;
  logic [7:0]    quo;
  logic [7:0]    val;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  localparam logic signed [HW+1:0] NR_ONE = {{(HW+1){1'b0}}, 1'b1};
  localparam logic signed [WW+1:0] NC_ONE = {{(WW+1){1'b0}}, 1'b1};

  // neighbour k: 0..7 around, 8 is centre
  logic signed [HW+1:0] nr;
  logic signed [WW+1:0] nc;
  logic nb_in;
  always_comb begin
    nr = $signed({2'b00, row});
    nc = $signed({2'b00, col});
    case (k)
      4'd0: begin nr = nr - NR_ONE; nc = nc - NC_ONE; end
      4'd1: begin nr = nr - NR_ONE; end
      4'd2: begin nr = nr - NR_ONE; nc = nc + NC_ONE; end
      4'd3: begin nc = nc - NC_ONE; end
      4'd4: begin nc = nc + NC_ONE; end
      4'd5: begin nr = nr + NR_ONE; nc = nc - NC_ONE; end
      4'd6: begin nr = nr + NR_ONE; end
      4'd7: begin nr = nr + NR_ONE; nc = nc + NC_ONE; end
      default: ;
    endcase
    nb_in = !nr[HW+1] && !nc[WW+1] && (nr < $signed({2'b00, eff_h}))
            && (nc < $signed({2'b00, eff_w}));
    rd_addr = AW'(nr[HW-1:0]) * AW'(eff_w) + AW'(nc[WW-1:0]);
  end

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      frame_done <= 1'b0;
      psum       <= '0;
    end else begin
      frame_done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            idx   <= job_idx;
            lst   <= job_last;
            row   <= '0;
            col   <= '0;
            rem   <= job_idx;
            // first pixel of a frame starts a fresh sum
            if (job_idx == '0) psum <= '0;
            state <= S_POS;
          end
        end
        S_POS: begin
          // row by repeated subtraction of the width
          if (rem >= CW'(eff_w)) begin
            rem <= rem - CW'(eff_w);
            row <= row + 1'b1;
          end else begin
            col     <= rem[WW-1:0];
            k       <= 4'd0;
            rd_pend <= 1'b0;
            hit     <= 1'b0;
            state   <= S_NB;
          end
        end
        S_NB: begin
          if (rd_pend && k == 4'd9) begin
            val <= hit ? 8'd0 : rd_data;
            psum <= psum + (hit ? '0 : SUM_W'(rd_data));
            quo_rem <= psum + (hit ? '0 : SUM_W'(rd_data));
            quo <= '0;
            state <= lst ? S_DIV : S_OUT;
          end else begin
            if (rd_pend && (rd_data == run_max || rd_data == run_min
                            || rd_data == target)) hit <= 1'b1;
            rd_pend <= (k == 4'd8) || nb_in;
            k <= k + 1'b1;
          end
        end
        S_DIV: begin
          if (quo_rem >= SUM_W'(total) && quo != 8'd255) begin
            quo_rem <= quo_rem - SUM_W'(total);
            quo     <= quo + 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_take) begin
            frame_done <= 1'b1;
            if (lst) psum <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_item.pixel_out     = val;
    out_item.inverted_out  = 8'd255 - val;
    out_item.frame_average = lst ? quo : 8'd0;
    out_item.last          = lst;
  end

  logic unused_idx;
  assign unused_idx = ^idx;
endmodule

>>> bench/extreme_pixel_neighbour_blanking_test.sv
`timescale 1ns / 100ps

module extreme_pixel_neighbour_blanking_test;
  import epnb_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SETTLE = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_GOAL = 1400;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       op;
    logic [7:0] px;
    logic [1:0] regsel;
    logic [6:0] value;
    logic       typed;
    logic       has;
    out_item_t  exp;
  } row_t;

  localparam out_item_t NONE = '0;

  // single-pixel frame, short 3x2 frame, then a shrink while part read
  localparam row_t PLAN [31] = '{
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b1, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_HEIGHT, 7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd255, REG_WIDTH,  7'd0, 1'b1, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd0,   REG_WIDTH,  7'd0, 1'b1, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b1, 1'b1,
      '{8'd255, 8'd0, 8'd255, 1'b1}},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_WIDTH,  7'd3, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_HEIGHT, 7'd2, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_TARGET, 7'd127, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd10,  REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd20,  REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd127, REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd40,  REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd50,  REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd60,  REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd255, REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd255, REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd7,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd128, REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd1,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_LOAD, 8'd254, REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_WIDTH,  7'd1, 1'b0, 1'b0, NONE},
    '{ROW_CFG,  OP_LOAD, 8'd0,   REG_HEIGHT, 7'd1, 1'b0, 1'b0, NONE},
    '{ROW_ITEM, OP_READ, 8'd0,   REG_WIDTH,  7'd0, 1'b1, 1'b0, NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  extreme_pixel_neighbour_blanking dut (
    .clk, .rst, .push, .full, .in_item, .empty, .pop, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the block
  logic [6:0] cfg_width = RESET_WIDTH;
  logic [6:0] cfg_height = RESET_HEIGHT;
  logic [7:0] cfg_target = RESET_TARGET;
  logic [7:0] pixels [STORE_DEPTH];
  logic [7:0] peak = 8'd0;
  logic [7:0] trough = 8'd255;
  int unsigned loaded = 0;
  int unsigned served = 0;
  logic [19:0] level_sum = '0;

  out_item_t pending_pixels [$];
  int errors = 0;
  int useful_items = 0;
  int popped = 0;
  bit calm = 1'b0;

  function automatic int unsigned frame_w();
    return (cfg_width == 0) ? 1 : (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
  endfunction

  function automatic int unsigned frame_h();
    return (cfg_height == 0) ? 1 :
           (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
  endfunction

  function automatic void restart_frame();
    peak = 8'd0;
    trough = 8'd255;
    loaded = 0;
    served = 0;
    level_sum = '0;
  endfunction

  function automatic bit is_marked(logic [7:0] v);
    return v == peak || v == trough || v == cfg_target;
  endfunction

  function automatic logic [7:0] blanked_pixel(int unsigned idx, int w, int h);
    int row;
    int col;
    row = idx / w;
    col = idx % w;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && row + dr >= 0 && col + dc >= 0 &&
            row + dr < h && col + dc < w) begin
          if (is_marked(pixels[(row + dr) * w + col + dc])) return 8'd0;
        end
      end
    end
    return pixels[idx];
  endfunction

  function automatic void blank_step(input in_item_t it, output out_item_t res,
                                     output bit has, output bit took);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    logic [7:0] v;
    w = frame_w();
    h = frame_h();
    total = w * h;
    res = '0;
    has = 1'b0;
    took = 1'b0;
    if (it.operation == OP_LOAD) begin
      if (loaded < total) begin
        pixels[loaded] = it.pixel_in;
        if (it.pixel_in > peak) peak = it.pixel_in;
        if (it.pixel_in < trough) trough = it.pixel_in;
        loaded++;
        took = 1'b1;
      end
    end else if (loaded >= total) begin
      if (served >= total) begin
        restart_frame();
      end else begin
        v = blanked_pixel(served, w, h);
        level_sum = level_sum + v;
        res.pixel_out = v;
        res.inverted_out = 8'd255 - v;
        has = 1'b1;
        took = 1'b1;
        if (served + 1 >= total) begin
          res.frame_average = 8'(level_sum / total);
          res.last = 1'b1;
          restart_frame();
        end else begin
          served++;
        end
      end
    end
  endfunction

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
    errors++;
  endtask

  task automatic offer(in_item_t it, bit typed, bit thas, out_item_t texp);
    out_item_t res;
    bit has;
    bit took;
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    blank_step(it, res, has, took);
    if (typed) begin
      has = thas;
      res = texp;
    end
    if (has) pending_pixels = {pending_pixels, res};
    if (took) useful_items++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // sender holds back until every result is out and the block has settled
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] regsel, logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regsel)
      REG_WIDTH:  cfg_width = value;
      REG_HEIGHT: cfg_height = value;
      default:    cfg_target = {1'b0, value};
    endcase
  endtask

  // target is 8 bits wide, so it gets its own writer
  task automatic write_target(logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TARGET, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_target = value;
  endtask

  function automatic logic [7:0] scene_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return cfg_target;
      3: return 8'($urandom_range(100, 103));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: random pop gaps plus one long hold-off
  int pop_gap = 0;
  int hold = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $display("unexpected result transfer at %0t", $time);
          errors++;
        end else begin
          if (out_item.pixel_out !== pending_pixels[0].pixel_out)
            report("pixel_out", out_item.pixel_out, pending_pixels[0].pixel_out);
          if (out_item.inverted_out !== pending_pixels[0].inverted_out)
            report("inverted_out", out_item.inverted_out, pending_pixels[0].inverted_out);
          if (out_item.frame_average !== pending_pixels[0].frame_average)
            report("frame_average", out_item.frame_average,
                   pending_pixels[0].frame_average);
          if (out_item.last !== pending_pixels[0].last)
            report("last", 8'(out_item.last), 8'(pending_pixels[0].last));
          void'(pending_pixels.pop_front());
        end
        popped++;
      end
      if (!held_once && popped == 300) begin
        held_once = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop_gap = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_item_t it;
    int steps;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain();
        if (PLAN[i].regsel == REG_TARGET) write_target({1'b0, PLAN[i].value});
        else write_reg(PLAN[i].regsel, PLAN[i].value);
      end else begin
        it.operation = PLAN[i].op;
        it.pixel_in = PLAN[i].px;
        offer(it, PLAN[i].typed, PLAN[i].has, PLAN[i].exp);
      end
    end

    while (useful_items < ITEM_GOAL) begin
      drain();
      case ($urandom_range(0, 7))
        0: begin
          write_reg(REG_WIDTH, $urandom_range(0, 1) ? 7'd64 : 7'd127);
          write_reg(REG_HEIGHT, 7'($urandom_range(0, 2)));
        end
        1: begin
          write_reg(REG_WIDTH, 7'($urandom_range(0, 1)));
          write_reg(REG_HEIGHT, $urandom_range(0, 1) ? 7'd64 : 7'd100);
        end
        2: begin
          write_reg(REG_WIDTH, 7'd0);
          write_reg(REG_HEIGHT, 7'd0);
        end
        default: begin
          write_reg(REG_WIDTH, 7'($urandom_range(1, 8)));
          write_reg(REG_HEIGHT, 7'($urandom_range(1, 8)));
        end
      endcase
      case ($urandom_range(0, 3))
        0: write_target(8'd0);
        1: write_target(8'd255);
        default: write_target(8'($urandom_range(0, 255)));
      endcase
      steps = $urandom_range(20, 200);
      if (useful_items > ITEM_GOAL - 150) calm = 1'b1;
      repeat (steps) begin
        if ($urandom_range(0, 11) == 0) begin
          it.operation = 1'($urandom_range(0, 1));
          it.pixel_in = 8'($urandom_range(0, 255));
        end else begin
          it.operation = (loaded < frame_w() * frame_h()) ? OP_LOAD : OP_READ;
          it.pixel_in = (it.operation == OP_LOAD) ? scene_level() :
                        8'($urandom_range(0, 255));
        end
        offer(it, 1'b0, 1'b0, NONE);
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
